[hdl/dfbp_pkg.sv]
// Package for the dual frame byte parser: frame codes, lengths and the
// result record type. No dependencies.
package dfbp_pkg;

   localparam logic [7:0] SHAPE_START = 8'h7B;
   localparam logic [7:0] SHAPE_END   = 8'h7A;
   localparam logic [7:0] CMD_START   = 8'h7D;
   localparam logic [7:0] CMD_END     = 8'h7C;

   localparam int SHAPE_LEN   = 14;
   localparam int CMD_LEN     = 4;
   localparam int SHAPE_BYTES = SHAPE_LEN - 2;
   localparam int CMD_BYTES   = CMD_LEN - 2;

   localparam int SHAPE_CNT_W = $clog2(SHAPE_LEN);
   localparam int CMD_CNT_W   = $clog2(CMD_LEN);
   localparam int SHAPE_IDX_W = $clog2(SHAPE_BYTES);
   localparam int CMD_IDX_W   = $clog2(CMD_BYTES);

   localparam logic [SHAPE_CNT_W-1:0] SHAPE_LAST = SHAPE_CNT_W'(SHAPE_LEN - 1);
   localparam logic [CMD_CNT_W-1:0]   CMD_LAST   = CMD_CNT_W'(CMD_LEN - 1);

   typedef struct packed {
      logic        shape_valid;
      logic        cmd_valid;
      logic [15:0] point0_x;
      logic [15:0] point0_y;
      logic [15:0] point1_x;
      logic [15:0] point1_y;
      logic [15:0] point2_x;
      logic [15:0] point2_y;
      logic [7:0]  drive_mode;
      logic [7:0]  drive_speed;
      logic        cmd_seen;
   } rsp_type;

endpackage

[hdl/dual_frame_byte_parser.sv]
// Dual frame byte parser top level: shape and command frame parsers fed
// from one byte stream, with a two-entry result register (output + skid).
// Depends on dfbp_pkg.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_shape_valid .. rsp_cmd_seen
//
// One byte per cycle while req_stall is low; each result is registered.
// The parsers update in the accepting cycle; the result goes to the output
// register, or to the skid register when the output is held by rsp_stall.
// req_stall is high only while the skid register is occupied.
// Synchronous active-high reset clears both parsers, latched command values
// and the result valids; payload bytes are not reset.
module dual_frame_byte_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_shape_valid,
   output logic       rsp_cmd_valid,
   output logic [15:0] rsp_point0_x,
   output logic [15:0] rsp_point0_y,
   output logic [15:0] rsp_point1_x,
   output logic [15:0] rsp_point1_y,
   output logic [15:0] rsp_point2_x,
   output logic [15:0] rsp_point2_y,
   output logic [7:0] rsp_drive_mode,
   output logic [7:0] rsp_drive_speed,
   output logic       rsp_cmd_seen
);
   import dfbp_pkg::*;

   logic [SHAPE_CNT_W-1:0] shape_count_ff, shape_count_in;
   logic [CMD_CNT_W-1:0]   cmd_count_ff, cmd_count_in, cmd_count_eff;
   logic [7:0]             shape_payload_ff [SHAPE_BYTES];
   logic [7:0]             cmd_payload_ff [CMD_BYTES];
   logic [7:0]             mode_ff, mode_in;
   logic [7:0]             speed_ff, speed_in;
   logic                   seen_ff, seen_in;

   logic                   shape_wr, cmd_wr;
   logic [SHAPE_IDX_W-1:0] shape_idx;
   logic [CMD_IDX_W-1:0]   cmd_idx;
   logic                   shape_ok, cmd_ok;

   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff, rsp_in;
   logic    accept, out_free;

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Parser next state for the current byte
   always_comb begin
      shape_count_in = shape_count_ff;
      cmd_count_in   = cmd_count_ff;
      mode_in        = mode_ff;
      speed_in       = speed_ff;
      seen_in        = seen_ff;
      shape_wr       = 1'b0;
      cmd_wr         = 1'b0;
      shape_ok       = 1'b0;
      cmd_ok         = 1'b0;
      shape_idx      = SHAPE_IDX_W'(shape_count_ff - 1'b1);
      cmd_idx        = CMD_IDX_W'(cmd_count_ff - 1'b1);

      if (shape_count_ff == '0) begin
         if (req_rx_byte == SHAPE_START) shape_count_in = SHAPE_CNT_W'(1);
      end else if (shape_count_ff >= SHAPE_LAST) begin
         shape_ok       = (req_rx_byte == SHAPE_END);
         shape_count_in = '0;
      end else begin
         shape_wr       = 1'b1;
         shape_count_in = shape_count_ff + 1'b1;
      end

      // a good shape frame restarts the command parser before it sees this byte
      cmd_count_eff = shape_ok ? '0 : cmd_count_ff;
      if (cmd_count_eff == '0) begin
         cmd_count_in = (req_rx_byte == CMD_START) ? CMD_CNT_W'(1) : '0;
      end else if (cmd_count_eff >= CMD_LAST) begin
         if (req_rx_byte == CMD_END) begin
            cmd_ok         = 1'b1;
            mode_in        = cmd_payload_ff[0];
            speed_in       = cmd_payload_ff[1];
            seen_in        = 1'b1;
            shape_count_in = '0;
         end
         cmd_count_in = '0;
      end else begin
         cmd_wr       = 1'b1;
         cmd_count_in = cmd_count_eff + 1'b1;
      end

      rsp_in.shape_valid = shape_ok;
      rsp_in.cmd_valid   = cmd_ok;
      rsp_in.point0_x    = shape_ok ? {shape_payload_ff[0],  shape_payload_ff[1]}  : '0;
      rsp_in.point0_y    = shape_ok ? {shape_payload_ff[2],  shape_payload_ff[3]}  : '0;
      rsp_in.point1_x    = shape_ok ? {shape_payload_ff[4],  shape_payload_ff[5]}  : '0;
      rsp_in.point1_y    = shape_ok ? {shape_payload_ff[6],  shape_payload_ff[7]}  : '0;
      rsp_in.point2_x    = shape_ok ? {shape_payload_ff[8],  shape_payload_ff[9]}  : '0;
      rsp_in.point2_y    = shape_ok ? {shape_payload_ff[10], shape_payload_ff[11]} : '0;
      rsp_in.drive_mode  = mode_in;
      rsp_in.drive_speed = speed_in;
      rsp_in.cmd_seen    = seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_count_ff <= '0;
         cmd_count_ff   <= '0;
         mode_ff        <= '0;
         speed_ff       <= '0;
         seen_ff        <= 1'b0;
      end else if (accept) begin
         shape_count_ff <= shape_count_in;
         cmd_count_ff   <= cmd_count_in;
         mode_ff        <= mode_in;
         speed_ff       <= speed_in;
         seen_ff        <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && shape_wr) shape_payload_ff[shape_idx] <= req_rx_byte;
      if (accept && cmd_wr)   cmd_payload_ff[cmd_idx]     <= req_rx_byte;
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : rsp_in;
      end else if (accept) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_shape_valid = out_ff.shape_valid;
   assign rsp_cmd_valid   = out_ff.cmd_valid;
   assign rsp_point0_x    = out_ff.point0_x;
   assign rsp_point0_y    = out_ff.point0_y;
   assign rsp_point1_x    = out_ff.point1_x;
   assign rsp_point1_y    = out_ff.point1_y;
   assign rsp_point2_x    = out_ff.point2_x;
   assign rsp_point2_y    = out_ff.point2_y;
   assign rsp_drive_mode  = out_ff.drive_mode;
   assign rsp_drive_speed = out_ff.drive_speed;
   assign rsp_cmd_seen    = out_ff.cmd_seen;

endmodule
